// ----- src/dirty_grain_bitmap_tracker_defines.svh -----
// ----------------------------------------------------------------------------
// dirty grain bitmap tracker assertion macros
// shared concurrent assertion forms, clocked on clk_i, off while in reset
// ----------------------------------------------------------------------------
`ifndef DIRTY_GRAIN_BITMAP_TRACKER_DEFINES_SVH
`define DIRTY_GRAIN_BITMAP_TRACKER_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define DGBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define DGBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dgbt_pkg.sv -----
// ----------------------------------------------------------------------------
// dgbt_pkg
// sizes, request and register codes, divider step for the dirty grain tracker
// ----------------------------------------------------------------------------
package dgbt_pkg;

  // bitmap geometry
  localparam int unsigned MAP_BYTES      = 16384;
  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned SECTOR_SHIFT   = 9;
  localparam int unsigned BITS_PER_HALF  = MAP_BYTES * 8;
  localparam int unsigned WORDS_PER_HALF = BITS_PER_HALF / WORD_BITS;
  localparam int unsigned STORE_WORDS    = 2 * WORDS_PER_HALF;
  localparam int unsigned BIT_W          = $clog2(WORD_BITS);
  localparam int unsigned GRAIN_W        = $clog2(BITS_PER_HALF);
  localparam int unsigned WIDX_W         = GRAIN_W - BIT_W;
  localparam int unsigned ADDR_W         = WIDX_W + 1;

  // port field widths
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned OFFSET_W    = 48;
  localparam int unsigned LENGTH_W    = 32;
  localparam int unsigned WINDEX_W    = 12;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned GRAIN_OUT_W = 17;
  localparam int unsigned GSECT_W     = 24;
  localparam int unsigned TOTAL_W     = 18;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 24;

  // end sector of offset+length, one carry bit wider than the offset
  localparam int unsigned SECT_W    = OFFSET_W + 1 - SECTOR_SHIFT;
  localparam int unsigned DIV_CNT_W = $clog2(SECT_W + 1);

  // request codes
  localparam logic [REQ_W-1:0] REQ_TRACK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FLIP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RD    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_WR    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd2;

  localparam logic [GSECT_W-1:0] GRAIN_RESET = 24'd128;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 18'd131072;

  // restoring divider state: quotient bits shift in where dividend bits leave
  typedef struct packed {
    logic [GSECT_W-1:0] rem;
    logic [SECT_W-1:0]  quo;
  } div_t;

  function automatic div_t div_step(div_t cur, logic [GSECT_W-1:0] dvs);
    logic [GSECT_W:0] trial;
    div_t             nxt;
    trial = {cur.rem, cur.quo[SECT_W-1]};
    if (trial >= {1'b0, dvs}) begin
      nxt.rem = GSECT_W'(trial - {1'b0, dvs});
      nxt.quo = {cur.quo[SECT_W-2:0], 1'b1};
    end else begin
      nxt.rem = trial[GSECT_W-1:0];
      nxt.quo = {cur.quo[SECT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// ----- src/dirty_grain_bitmap_tracker.sv -----
// ----------------------------------------------------------------------------
// dirty grain bitmap tracker
// double-buffered dirty bitmap: tracked writes mark grains in the active half,
// host word access reaches the inactive half, a flip swaps the two
// ----------------------------------------------------------------------------
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-----------------------------------
//  in       | in_valid_i / in_stall_o       | req_type, byte_offset, byte_length,
//           |                               | word_index, word_data
//  out      | out_valid_o / out_stall_i     | read_data, active_half,
//           |                               | first_grain, last_grain
//  cfg      | cfg_we_i, cfg_idx_i           | cfg_data_i
//
//  flip, host write and a write with tracking off: S_DONE, then output register
//  host read: registered read of the bitmap memory, S_RD_WAIT, S_DONE, output
//  tracked write: the shift-subtract divider makes 40 quotient bits one a
//  cycle, then each bitmap word touched takes one read and one write on the
//  memory; one item is in flight at a time
//  after reset a clearing pass zeroes the 8192-word memory with the input
//  stalled; a stalled result waits in the output register
// ----------------------------------------------------------------------------
`include "dirty_grain_bitmap_tracker_defines.svh"

module dirty_grain_bitmap_tracker
  import dgbt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,

  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [REQ_W-1:0]       req_type_i,
  input  logic [OFFSET_W-1:0]    byte_offset_i,
  input  logic [LENGTH_W-1:0]    byte_length_i,
  input  logic [WINDEX_W-1:0]    word_index_i,
  input  logic [DATA_W-1:0]      word_data_i,

  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DATA_W-1:0]      read_data_o,
  output logic                   active_half_o,
  output logic [GRAIN_OUT_W-1:0] first_grain_o,
  output logic [GRAIN_OUT_W-1:0] last_grain_o
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_RD_WAIT = 3'd2;
  localparam logic [2:0] S_DIV     = 3'd3;
  localparam logic [2:0] S_SAT     = 3'd4;
  localparam logic [2:0] S_MARK_RD = 3'd5;
  localparam logic [2:0] S_MARK_WR = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  // control state
  logic [2:0]           state_q, state_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;
  logic                 half_q, half_d;
  logic                 out_valid_q, out_valid_d;
  logic                 track_en_q;
  logic [GSECT_W-1:0]   grain_q;
  logic [TOTAL_W-1:0]   total_q;

  // payload registers
  div_t                 div_a_q, div_a_d, div_b_q, div_b_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [GRAIN_W-1:0]   first_q, first_d, last_q, last_d;
  logic [WIDX_W-1:0]    w_q, w_d;
  logic [DATA_W-1:0]    res_rd_q, res_rd_d;
  logic [DATA_W-1:0]    out_rd_q;
  logic                 out_half_q;
  logic [GRAIN_W-1:0]   out_first_q, out_last_q;

  // bitmap memory
  logic [WORD_BITS-1:0] dirty_store [STORE_WORDS];
  logic [WORD_BITS-1:0] mem_rd_q;
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic                 in_acc, out_load;
  logic [WIDX_W-1:0]    host_idx;
  logic [OFFSET_W:0]    end_byte;
  logic [GRAIN_W-1:0]   max_grain, sat_a, sat_b;
  logic [WIDX_W-1:0]    last_word;
  logic [WORD_BITS-1:0] mark_mask;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign host_idx   = WIDX_W'(32'(word_index_i));
  assign end_byte   = {1'b0, byte_offset_i} + (OFFSET_W + 1)'(byte_length_i);
  assign last_word  = last_q[GRAIN_W-1:BIT_W];

  // highest usable grain: total_bits clamped to the half, zero acting as one
  always_comb begin
    if (total_q == '0) begin
      max_grain = '0;
    end else if (32'(total_q) >= BITS_PER_HALF) begin
      max_grain = GRAIN_W'(BITS_PER_HALF - 1);
    end else begin
      max_grain = GRAIN_W'(total_q - 1'b1);
    end
  end

  // saturate quotients; a zero grain size maps everything to the top grain
  always_comb begin
    if (grain_q == '0 || div_a_q.quo > SECT_W'(max_grain)) begin
      sat_a = max_grain;
    end else begin
      sat_a = GRAIN_W'(div_a_q.quo);
    end
    if (grain_q == '0 || div_b_q.quo > SECT_W'(max_grain)) begin
      sat_b = max_grain;
    end else begin
      sat_b = GRAIN_W'(div_b_q.quo);
    end
  end

  always_comb begin
    mark_mask = {WORD_BITS{1'b1}};
    if (w_q == first_q[GRAIN_W-1:BIT_W]) begin
      mark_mask = mark_mask & ({WORD_BITS{1'b1}} << first_q[BIT_W-1:0]);
    end
    if (w_q == last_word) begin
      mark_mask = mark_mask
                & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_q[BIT_W-1:0]));
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    half_d      = half_q;
    div_a_d     = div_a_q;
    div_b_d     = div_b_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    last_d      = last_q;
    w_d         = w_q;
    res_rd_d    = res_rd_q;
    mem_we      = 1'b0;
    mem_waddr   = {half_q, w_q};
    mem_wdata   = mem_rd_q | mark_mask;
    mem_re      = 1'b0;
    mem_raddr   = {half_q, w_q};

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_rd_d = '0;
          first_d  = '0;
          last_d   = '0;
          unique case (req_type_i)
            REQ_TRACK: begin
              div_a_d.rem = '0;
              div_a_d.quo = SECT_W'(byte_offset_i >> SECTOR_SHIFT);
              div_b_d.rem = '0;
              div_b_d.quo = SECT_W'(end_byte >> SECTOR_SHIFT);
              cnt_d       = '0;
              state_d     = track_en_q ? S_DIV : S_DONE;
            end
            REQ_FLIP: begin
              half_d  = ~half_q;
              state_d = S_DONE;
            end
            REQ_RD: begin
              mem_re    = 1'b1;
              mem_raddr = {~half_q, host_idx};
              state_d   = S_RD_WAIT;
            end
            REQ_WR: begin
              mem_we    = 1'b1;
              mem_waddr = {~half_q, host_idx};
              mem_wdata = word_data_i;
              state_d   = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_RD_WAIT: begin
        res_rd_d = mem_rd_q;
        state_d  = S_DONE;
      end
      S_DIV: begin
        div_a_d = div_step(div_a_q, grain_q);
        div_b_d = div_step(div_b_q, grain_q);
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(SECT_W - 1)) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        first_d = sat_a;
        last_d  = sat_b;
        w_d     = sat_a[GRAIN_W-1:BIT_W];
        state_d = S_MARK_RD;
      end
      S_MARK_RD: begin
        mem_re  = 1'b1;
        state_d = S_MARK_WR;
      end
      S_MARK_WR: begin
        // read data of this word arrived from the previous cycle
        mem_we = 1'b1;
        if (w_q == last_word) begin
          state_d = S_DONE;
        end else begin
          w_d     = w_q + 1'b1;
          state_d = S_MARK_RD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
      track_en_q  <= 1'b0;
      grain_q     <= GRAIN_RESET;
      total_q     <= TOTAL_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TRACK: track_en_q <= cfg_data_i[0];
          CFG_GRAIN: grain_q    <= cfg_data_i[GSECT_W-1:0];
          CFG_TOTAL: total_q    <= cfg_data_i[TOTAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    div_a_q  <= div_a_d;
    div_b_q  <= div_b_d;
    cnt_q    <= cnt_d;
    first_q  <= first_d;
    last_q   <= last_d;
    w_q      <= w_d;
    res_rd_q <= res_rd_d;
    if (out_load) begin
      out_rd_q    <= res_rd_q;
      out_half_q  <= half_q;
      out_first_q <= first_q;
      out_last_q  <= last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dirty_store[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rd_q <= dirty_store[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_rd_q;
  assign active_half_o = out_half_q;
  assign first_grain_o = GRAIN_OUT_W'(32'(out_first_q));
  assign last_grain_o  = GRAIN_OUT_W'(32'(out_last_q));

  `DGBT_ASSERT_NOW(a_accept_only_idle, in_valid_i && !in_stall_o, state_q == S_IDLE, "beat accepted outside idle")
  `DGBT_ASSERT_NOW(a_mark_in_range, state_q == S_MARK_RD || state_q == S_MARK_WR, w_q <= last_word && first_q <= last_q, "marking walked past the last word")
  `DGBT_ASSERT_NEXT(a_done_loads_output, out_load, out_valid_q && state_q == S_IDLE, "finished result not presented")
  `DGBT_ASSERT_NOW(a_clear_no_result, state_q == S_CLEAR, !out_valid_q && in_stall_o, "result or beat during clearing pass")

endmodule

// ----- sim/dirty_grain_bitmap_checker.sv -----
// ----------------------------------------------------------------------------
// dirty grain bitmap checker
// watches the config port and both channels, keeps its own copy of the
// double-buffered bitmap, predicts every result beat and compares it
// ----------------------------------------------------------------------------
module dirty_grain_bitmap_checker
  import dgbt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,

  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [REQ_W-1:0]       req_type_i,
  input  logic [OFFSET_W-1:0]    byte_offset_i,
  input  logic [LENGTH_W-1:0]    byte_length_i,
  input  logic [WINDEX_W-1:0]    word_index_i,
  input  logic [DATA_W-1:0]      word_data_i,

  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [DATA_W-1:0]      read_data_i,
  input  logic                   active_half_i,
  input  logic [GRAIN_OUT_W-1:0] first_grain_i,
  input  logic [GRAIN_OUT_W-1:0] last_grain_i,

  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0]      read_data;
    logic                   active_half;
    logic [GRAIN_OUT_W-1:0] first_grain;
    logic [GRAIN_OUT_W-1:0] last_grain;
  } grain_result_t;

  grain_result_t        awaited_results [$];
  logic [WORD_BITS-1:0] bitmap_copy [STORE_WORDS];
  logic                 marking_half;
  logic                 tracking_on;
  logic [GSECT_W-1:0]   sectors_per_grain;
  logic [TOTAL_W-1:0]   grain_total;
  int unsigned          mismatch_cnt = 0;

  assign fail_count_o = mismatch_cnt;

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    if (mismatch_cnt < 40) begin
      $display("%0t ns: %s got %h want %h", $time, what, got, want);
    end
    mismatch_cnt++;
  endtask

  function automatic void clear_bitmap_copy();
    foreach (bitmap_copy[i]) bitmap_copy[i] = '0;
    marking_half      = 1'b0;
    tracking_on       = 1'b0;
    sectors_per_grain = GRAIN_RESET;
    grain_total       = TOTAL_RESET;
  endfunction

  // grain count in use: clamped to one half, zero acts as one
  function automatic logic [TOTAL_W-1:0] grains_in_use();
    logic [TOTAL_W-1:0] n;
    n = grain_total;
    if (n > BITS_PER_HALF) n = TOTAL_W'(BITS_PER_HALF);
    if (n == '0) n = TOTAL_W'(1);
    return n;
  endfunction

  function automatic logic [TOTAL_W-1:0] grain_of_sector(logic [SECT_W-1:0] sector);
    logic [TOTAL_W-1:0] n;
    logic [SECT_W-1:0]  q;
    n = grains_in_use();
    if (sectors_per_grain == '0) return n - 1'b1;
    q = sector / sectors_per_grain;
    if (q >= n) return n - 1'b1;
    return q[TOTAL_W-1:0];
  endfunction

  function automatic void mark_grain_span(logic [TOTAL_W-1:0] lo_g, logic [TOTAL_W-1:0] hi_g);
    int unsigned          base;
    int unsigned          lo_w;
    int unsigned          hi_w;
    int unsigned          w;
    logic [WORD_BITS-1:0] m;
    base = marking_half ? WORDS_PER_HALF : 0;
    lo_w = lo_g / WORD_BITS;
    hi_w = hi_g / WORD_BITS;
    for (w = lo_w; w <= hi_w; w++) begin
      m = '1;
      if (w == lo_w) m &= {WORD_BITS{1'b1}} << lo_g[BIT_W-1:0];
      if (w == hi_w) m &= {WORD_BITS{1'b1}} >> (WORD_BITS - 1 - hi_g[BIT_W-1:0]);
      bitmap_copy[base + w] |= m;
    end
  endfunction

  // applies one request to the bitmap copy and returns the beat it should give
  function automatic grain_result_t resolve_request(
    logic [REQ_W-1:0]    req,
    logic [OFFSET_W-1:0] off,
    logic [LENGTH_W-1:0] len,
    logic [WINDEX_W-1:0] widx,
    logic [DATA_W-1:0]   wdat
  );
    grain_result_t      r;
    logic [OFFSET_W:0]  stop_byte;
    logic [TOTAL_W-1:0] lo_g;
    logic [TOTAL_W-1:0] hi_g;
    int unsigned        host_word;
    r = '0;
    host_word = (marking_half ? 0 : WORDS_PER_HALF) + (widx % WORDS_PER_HALF);
    case (req)
      REQ_TRACK: begin
        if (tracking_on) begin
          // end sector is inclusive and may carry past the offset width
          stop_byte = {1'b0, off} + (OFFSET_W + 1)'(len);
          lo_g = grain_of_sector(SECT_W'(off >> SECTOR_SHIFT));
          hi_g = grain_of_sector(SECT_W'(stop_byte >> SECTOR_SHIFT));
          mark_grain_span(lo_g, hi_g);
          r.first_grain = lo_g[GRAIN_OUT_W-1:0];
          r.last_grain  = hi_g[GRAIN_OUT_W-1:0];
        end
      end
      REQ_FLIP: begin
        marking_half = ~marking_half;
      end
      REQ_RD: begin
        r.read_data = bitmap_copy[host_word];
      end
      default: begin
        bitmap_copy[host_word] = wdat;
      end
    endcase
    r.active_half = marking_half;
    return r;
  endfunction

  always @(posedge clk_i) begin
    grain_result_t want;
    if (!rst_ni) begin
      clear_bitmap_copy();
      awaited_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with nothing awaited", read_data_i, '0);
        end else begin
          want = awaited_results.pop_front();
          if (read_data_i !== want.read_data) begin
            report_mismatch("read_data", read_data_i, want.read_data);
          end
          if (active_half_i !== want.active_half) begin
            report_mismatch("active_half", DATA_W'(active_half_i), DATA_W'(want.active_half));
          end
          if (first_grain_i !== want.first_grain) begin
            report_mismatch("first_grain", DATA_W'(first_grain_i), DATA_W'(want.first_grain));
          end
          if (last_grain_i !== want.last_grain) begin
            report_mismatch("last_grain", DATA_W'(last_grain_i), DATA_W'(want.last_grain));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TRACK: tracking_on       = cfg_data_i[0];
          CFG_GRAIN: sectors_per_grain = cfg_data_i[GSECT_W-1:0];
          CFG_TOTAL: grain_total       = cfg_data_i[TOTAL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(resolve_request(req_type_i, byte_offset_i, byte_length_i,
                                                  word_index_i, word_data_i));
      end
    end
    pending_o <= awaited_results.size();
  end

endmodule

// ----- sim/tb_dirty_grain_bitmap_tracker.sv -----
// ----------------------------------------------------------------------------
// dirty grain bitmap tracker testbench
// directed requests on the corner cases, then random request streams under
// several register settings and idle/stall mixes; the checker does the scoring
// ----------------------------------------------------------------------------
module tb_dirty_grain_bitmap_tracker;
  import dgbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BATCHES      = 4;
  localparam int unsigned BATCH_ITEMS  = 110;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = CFG_TRACK;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [REQ_W-1:0]       req_type = REQ_TRACK;
  logic [OFFSET_W-1:0]    byte_offset = '0;
  logic [LENGTH_W-1:0]    byte_length = '0;
  logic [WINDEX_W-1:0]    word_index = '0;
  logic [DATA_W-1:0]      word_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DATA_W-1:0]      read_data;
  logic                   active_half;
  logic [GRAIN_OUT_W-1:0] first_grain;
  logic [GRAIN_OUT_W-1:0] last_grain;
  int unsigned            fail_count;
  int unsigned            pending;

  int unsigned            send_idle_pct = 0;
  int unsigned            stall_pct = 0;
  logic [GSECT_W-1:0]     cur_grain_size = GRAIN_RESET;
  logic [TOTAL_W-1:0]     cur_total = TOTAL_RESET;

  always #5 clk = ~clk;

  dirty_grain_bitmap_tracker dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .byte_offset_i (byte_offset),
    .byte_length_i (byte_length),
    .word_index_i  (word_index),
    .word_data_i   (word_data),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_o   (read_data),
    .active_half_o (active_half),
    .first_grain_o (first_grain),
    .last_grain_o  (last_grain)
  );

  dirty_grain_bitmap_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .req_type_i    (req_type),
    .byte_offset_i (byte_offset),
    .byte_length_i (byte_length),
    .word_index_i  (word_index),
    .word_data_i   (word_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_i   (read_data),
    .active_half_i (active_half),
    .first_grain_i (first_grain),
    .last_grain_i  (last_grain),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_beat(
    logic [REQ_W-1:0]    req,
    logic [OFFSET_W-1:0] off,
    logic [LENGTH_W-1:0] len,
    logic [WINDEX_W-1:0] widx,
    logic [DATA_W-1:0]   wdat
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    byte_offset <= off;
    byte_length <= len;
    word_index  <= widx;
    word_data   <= wdat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the input until every awaited result has come, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(logic en, logic [GSECT_W-1:0] gs, logic [TOTAL_W-1:0] tot);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TRACK;
    cfg_data <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_idx  <= CFG_GRAIN;
    cfg_data <= gs;
    @(posedge clk);
    cfg_idx  <= CFG_TOTAL;
    cfg_data <= CFG_DATA_W'(tot);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_grain_size = gs;
    cur_total      = tot;
  endtask

  task automatic load_preset(int unsigned sel);
    case (sel)
      0: load_settings(1'b1, GRAIN_RESET, TOTAL_RESET);
      1: load_settings(1'b1, 24'd1, TOTAL_W'(BITS_PER_HALF));
      2: load_settings(1'b1, 24'hFF_FFFF, TOTAL_W'(BITS_PER_HALF));
      3: load_settings(1'b1, 24'd0, 18'd1000);
      4: load_settings(1'b1, 24'd3, 18'd0);
      5: load_settings(1'b1, 24'd7, 18'h3FFFF);
      6: load_settings(1'b1, 24'd1, 18'd1);
      default: load_settings(1'b0, 24'd2, 18'd4096);
    endcase
  endtask

  task automatic send_random_request();
    logic [REQ_W-1:0]    req;
    logic [OFFSET_W-1:0] off;
    logic [LENGTH_W-1:0] len;
    logic [WINDEX_W-1:0] widx;
    longint unsigned     span;
    longint unsigned     grains;
    int unsigned         pick;
    pick = $urandom_range(99);
    if (pick < 45) req = REQ_TRACK;
    else if (pick < 58) req = REQ_FLIP;
    else if (pick < 80) req = REQ_RD;
    else req = REQ_WR;

    grains = (cur_total == '0) ? 1 : (cur_total > BITS_PER_HALF) ? BITS_PER_HALF : cur_total;
    span = grains * ((cur_grain_size == '0) ? 1 : cur_grain_size);
    if (span > 64'h7F_FFFF_FFFF) span = 64'h7F_FFFF_FFFF;

    // offsets mostly land inside the grain range in use, some saturate
    pick = $urandom_range(9);
    if (pick == 0) begin
      off = OFFSET_W'({$urandom, $urandom});
    end else if (pick == 1) begin
      off = {OFFSET_W{1'b1}} - OFFSET_W'($urandom_range(4095));
    end else begin
      off = {(OFFSET_W - SECTOR_SHIFT)'({$urandom, $urandom} % span), SECTOR_SHIFT'($urandom)};
    end

    // long spans are costly, so keep most writes short
    pick = $urandom_range(99);
    if (pick < 5) len = '0;
    else if (pick < 72) len = LENGTH_W'($urandom_range(4095));
    else if (pick < 97) len = $urandom & 32'h000F_FFFF;
    else len = $urandom;

    if ($urandom_range(1) != 0) widx = WINDEX_W'($urandom_range(32'((grains - 1) / WORD_BITS)));
    else widx = WINDEX_W'($urandom);

    send_beat(req, off, len, widx, $urandom);
  endtask

  initial begin
    int unsigned phase;
    int unsigned batch;
    int unsigned n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: tracking is off, host access to the inactive half
    send_beat(REQ_TRACK, '1, '1, '0, '0);
    send_beat(REQ_RD, '0, '0, 12'h000, '0);
    send_beat(REQ_WR, '0, '0, 12'hFFF, 32'hFFFF_FFFF);
    send_beat(REQ_RD, '0, '0, 12'hFFF, '0);
    send_beat(REQ_WR, '0, '0, 12'h000, 32'h0000_0000);
    drain_results();

    load_settings(1'b1, 24'd1, TOTAL_W'(BITS_PER_HALF));
    send_beat(REQ_TRACK, '0, '0, '0, '0);
    send_beat(REQ_TRACK, '1, '1, '0, '0);
    send_beat(REQ_TRACK, 48'd20480, 32'd51200, '0, '0);
    send_beat(REQ_FLIP, '0, '0, '0, '0);
    send_beat(REQ_RD, '0, '0, 12'd1, '0);
    send_beat(REQ_RD, '0, '0, 12'hFFF, '0);
    send_beat(REQ_WR, '0, '0, 12'd1, 32'hA5A5_A5A5);
    send_beat(REQ_FLIP, '0, '0, '0, '0);
    send_beat(REQ_RD, '0, '0, 12'd1, '0);
    drain_results();

    // zero grain size sends every sector to the top grain
    load_settings(1'b1, 24'd0, 18'd1000);
    send_beat(REQ_TRACK, 48'd12345, 32'd6789, '0, '0);
    drain_results();

    // zero total acts as a single grain
    load_settings(1'b1, 24'hFF_FFFF, 18'd0);
    send_beat(REQ_TRACK, '1, '1, '0, '0);
    drain_results();

    // oversize total clamps to the half, full-length write covers the half
    load_settings(1'b1, 24'd5, 18'h3FFFF);
    send_beat(REQ_TRACK, '1, '1, '0, '0);
    send_beat(REQ_TRACK, '0, 32'hFFFF_FFFF, '0, '0);
    send_beat(REQ_FLIP, '0, '0, '0, '0);
    send_beat(REQ_RD, '0, '0, 12'h000, '0);
    send_beat(REQ_RD, '0, '0, 12'hFFF, '0);
    send_beat(REQ_WR, '0, '0, 12'hFFF, 32'h0000_0000);
    drain_results();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      for (batch = 0; batch < BATCHES; batch++) begin
        drain_results();
        if (batch == BATCHES - 1) begin
          load_settings($urandom_range(99) < 90, GSECT_W'($urandom_range(4096, 1)),
                        TOTAL_W'($urandom_range(BITS_PER_HALF, 1)));
        end else begin
          load_preset((phase * 3 + batch) % 8);
        end
        for (n = 0; n < BATCH_ITEMS; n++) begin
          if (n == BATCH_ITEMS / 2) drain_results();
          send_random_request();
        end
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
